// File: design/tls_pkg.sv
`default_nettype none

package tls_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 1024;

    localparam int KEY_W       = 64;
    localparam int OP_W        = 2;
    localparam int IDX_FIELD_W = 10;
    localparam int USED_W      = 11;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 11;

    localparam int LANES  = 8;
    localparam int LANE_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE  = 2'd0,
        OP_LINEAR = 2'd1,
        OP_BINARY = 2'd2
    } op_t;

    localparam logic [CFG_IDX_W-1:0] CFG_USED_ENTRIES   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPARE_SIGNED = 1'b1;

    typedef struct packed {
        logic write_en;
        logic start_lin;
        logic start_bin;
        logic lin_step;
        logic bin_issue;
        logic bin_cmp;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic n_zero;
        logic lin_done;
        logic bin_done;
        logic out_free;
    } ctrl_status_t;

endpackage

`default_nettype wire

// File: design/tls_in_if.sv
`default_nettype none

interface tls_in_if;
    logic                             valid;
    logic                             ready;
    logic [tls_pkg::OP_W-1:0]         operation;
    logic [tls_pkg::IDX_FIELD_W-1:0]  index;
    logic [tls_pkg::KEY_W-1:0]        key_value;

    modport source (output valid, output operation, output index, output key_value,
                    input ready);
    modport sink   (input valid, input operation, input index, input key_value,
                    output ready);
endinterface

`default_nettype wire

// File: design/tls_out_if.sv
`default_nettype none

interface tls_out_if;
    logic                             valid;
    logic                             ready;
    logic                             found;
    logic [tls_pkg::IDX_FIELD_W-1:0]  position;

    modport source (output valid, output found, output position, input ready);
    modport sink   (input valid, input found, input position, output ready);
endinterface

`default_nettype wire

// File: design/tls_ram.sv
`default_nettype none

module tls_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: design/tls_datapath.sv
`default_nettype none

module tls_datapath #(
    parameter int TABLE_DEPTH = tls_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [tls_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [tls_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic [tls_pkg::IDX_FIELD_W-1:0]    index,
    input  wire logic [tls_pkg::KEY_W-1:0]          key_value,
    input  tls_pkg::ctrl_cmd_t                      cmd,
    output tls_pkg::ctrl_status_t                   status,
    tls_out_if.source                               out_ch
);
    import tls_pkg::*;

    localparam int ROWS   = (TABLE_DEPTH + LANES - 1) / LANES;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ROWC_W = $clog2(ROWS + 1);
    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    logic [USED_W-1:0]  used_reg;
    logic               signed_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [CNT_W-1:0]   n_reg;
    logic [ROWC_W-1:0]  row_reg;
    logic [ROWC_W-1:0]  rd_row_reg;
    logic               rd_valid_reg;
    logic               rd_valid_next;
    logic [CNT_W-1:0]   lo_reg;
    logic [CNT_W-1:0]   hi_reg;
    logic [IDX_W-1:0]   mid_reg;
    logic [LANE_W-1:0]  mid_lane_reg;
    logic               res_found_reg;
    logic [IDX_W-1:0]   res_pos_reg;
    logic               out_valid_reg;
    logic               out_found_reg;
    logic [IDX_W-1:0]   out_pos_reg;

    logic [CNT_W-1:0]   n_eff;
    logic               issue_more;
    logic [ROW_W-1:0]   raddr;
    logic [ROW_W-1:0]   waddr;
    logic               wr_ok;
    logic [KEY_W-1:0]   rd_data [LANES];
    logic               lin_hit;
    logic [LANE_W-1:0]  lin_lane;
    logic [CNT_W-1:0]   mid_c;
    logic [31:0]        mid32;
    logic [KEY_W-1:0]   probe;
    logic [KEY_W-1:0]   sflip;
    logic               bin_eq;
    logic               bin_gt;
    logic [CNT_W-1:0]   lo_next;
    logic [CNT_W-1:0]   hi_next;

    // effective count saturates at the table depth
    assign n_eff = (32'(used_reg) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : CNT_W'(used_reg);

    assign issue_more = 32'({row_reg, {LANE_W{1'b0}}}) < 32'(n_reg);

    assign mid_c = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign mid32 = 32'(mid_c);

    assign raddr = cmd.bin_issue ? ROW_W'(mid32 >> LANE_W) : row_reg[ROW_W-1:0];
    assign waddr = ROW_W'(32'(index) >> LANE_W);
    assign wr_ok = cmd.write_en && (32'(index) < TABLE_DEPTH);

    for (genvar l = 0; l < LANES; l++)
    begin : g_bank
        tls_ram #(
            .WIDTH (KEY_W),
            .DEPTH (ROWS)
        ) u_bank (
            .clk   (clk),
            .we    (wr_ok && (index[LANE_W-1:0] == LANE_W'(l))),
            .waddr (waddr),
            .wdata (key_value),
            .raddr (raddr),
            .rdata (rd_data[l])
        );
    end

    // lowest matching lane of the row below the count
    always_comb
    begin
        lin_hit  = 1'b0;
        lin_lane = '0;
        for (int l = LANES - 1; l >= 0; l--)
        begin
            if ((rd_data[l] == key_reg) &&
                (32'({rd_row_reg, LANE_W'(l)}) < 32'(n_reg)))
            begin
                lin_hit  = 1'b1;
                lin_lane = LANE_W'(l);
            end
        end
    end

    assign probe  = rd_data[mid_lane_reg];
    assign sflip  = {signed_reg, {(KEY_W-1){1'b0}}};
    assign bin_eq = (probe == key_reg);
    assign bin_gt = (probe ^ sflip) > (key_reg ^ sflip);

    always_comb
    begin
        if (bin_gt)
        begin
            lo_next = lo_reg;
            hi_next = CNT_W'(mid_reg);
        end
        else
        begin
            lo_next = CNT_W'(mid_reg) + CNT_W'(1);
            hi_next = hi_reg;
        end
    end

    assign status.n_zero   = (used_reg == '0);
    assign status.lin_done = rd_valid_reg && (lin_hit || !issue_more);
    assign status.bin_done = bin_eq || (lo_next >= hi_next);
    assign status.out_free = !out_valid_reg || out_ch.ready;

    assign rd_valid_next = cmd.lin_step && issue_more && !status.lin_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            signed_reg    <= 1'b0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_USED_ENTRIES)
                begin
                    used_reg <= cfg_data[USED_W-1:0];
                end
                else if (cfg_index == CFG_COMPARE_SIGNED)
                begin
                    signed_reg <= cfg_data[0];
                end
            end
            rd_valid_reg <= rd_valid_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_lin || cmd.start_bin)
        begin
            key_reg       <= key_value;
            n_reg         <= n_eff;
            res_found_reg <= 1'b0;
            res_pos_reg   <= '0;
            row_reg       <= '0;
            lo_reg        <= '0;
            hi_reg        <= n_eff;
        end
        if (cmd.lin_step)
        begin
            if (issue_more)
            begin
                row_reg <= row_reg + ROWC_W'(1);
            end
            rd_row_reg <= row_reg;
            if (rd_valid_reg && lin_hit)
            begin
                res_found_reg <= 1'b1;
                res_pos_reg   <= IDX_W'({rd_row_reg, lin_lane});
            end
        end
        if (cmd.bin_issue)
        begin
            mid_reg      <= IDX_W'(mid_c);
            mid_lane_reg <= mid32[LANE_W-1:0];
        end
        if (cmd.bin_cmp)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
            if (bin_eq)
            begin
                res_found_reg <= 1'b1;
                res_pos_reg   <= mid_reg;
            end
        end
        if (cmd.load_out)
        begin
            out_found_reg <= res_found_reg;
            out_pos_reg   <= res_pos_reg;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.found    = out_found_reg;
    assign out_ch.position = IDX_FIELD_W'(out_pos_reg);

    a_rd_valid_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> $past(cmd.lin_step))
        else $error("row data marked valid outside a linear scan");

    a_window_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.bin_cmp |-> (lo_reg < hi_reg))
        else $error("binary probe compared on an empty window");

    a_hit_below_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && res_found_reg) |-> (32'(res_pos_reg) < 32'(n_reg)))
        else $error("reported position not below the entry count");

endmodule

`default_nettype wire

// File: design/tls_ctrl.sv
`default_nettype none

module tls_ctrl (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire logic [tls_pkg::OP_W-1:0]   in_op,
    output logic                            in_ready,
    input  tls_pkg::ctrl_status_t           status,
    output tls_pkg::ctrl_cmd_t              cmd
);
    import tls_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_LIN     = 5'b00010,
        ST_BIN_RD  = 5'b00100,
        ST_BIN_CMP = 5'b01000,
        ST_DONE    = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (op_t'(in_op))
                        OP_WRITE:
                        begin
                            cmd.write_en = 1'b1;
                        end
                        OP_LINEAR:
                        begin
                            cmd.start_lin = 1'b1;
                            state_next    = status.n_zero ? ST_DONE : ST_LIN;
                        end
                        OP_BINARY:
                        begin
                            cmd.start_bin = 1'b1;
                            state_next    = status.n_zero ? ST_DONE : ST_BIN_RD;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LIN:
            begin
                cmd.lin_step = 1'b1;
                if (status.lin_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_BIN_RD:
            begin
                cmd.bin_issue = 1'b1;
                state_next    = ST_BIN_CMP;
            end
            ST_BIN_CMP:
            begin
                cmd.bin_cmp = 1'b1;
                state_next  = status.bin_done ? ST_DONE : ST_BIN_RD;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: design/table_linear_and_binary_search.sv
// Key table of TABLE_DEPTH 64-bit entries held in eight RAM banks, so that one
// row of eight consecutive entries is read per cycle. A write item is stored in
// its bank while the controller stays idle. A linear search scans rows from
// index zero, one row per read as each bank has a single read port, and stops
// early on a hit. Each binary-search probe is a bank read, then a compare and
// narrow. Results sit in an output register, so the next item is taken once a
// result is loaded there, even if it has not been collected yet; a finished
// search waits while the previous result is still held uncollected there.
// Table entries must be written before a search reads them.
`default_nettype none

module table_linear_and_binary_search #(
    parameter int TABLE_DEPTH = tls_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [tls_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tls_pkg::CFG_DATA_W-1:0] cfg_data,
    tls_in_if.sink                              in_ch,
    tls_out_if.source                           out_ch
);
    import tls_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    tls_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_op    (in_ch.operation),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    tls_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .index     (in_ch.index),
        .key_value (in_ch.key_value),
        .cmd       (cmd),
        .status    (status),
        .out_ch    (out_ch)
    );

endmodule

`default_nettype wire
